>>> rtl/core/pfau_pkg.sv
// shared operation codes and job kinds for the prime field arithmetic unit
`timescale 1ns / 1ps
package pfau_pkg;
	localparam logic [2:0] FUNC_ADD = 3'd0;
	localparam logic [2:0] FUNC_SUB = 3'd1;
	localparam logic [2:0] FUNC_MUL = 3'd2;
	localparam logic [2:0] FUNC_DIV = 3'd3;
	localparam logic [2:0] FUNC_INV = 3'd4;
	localparam logic [2:0] FUNC_POW = 3'd5;

	// classified job kinds handed from front to back
	localparam logic [1:0] JOB_DONE = 2'd0; // value already known
	localparam logic [1:0] JOB_POW = 2'd1;  // base^e
	localparam logic [1:0] JOB_DIV = 2'd2;  // a * b^e
	localparam logic [1:0] JOB_MUL = 2'd3;  // a * b
endpackage

>>> rtl/core/prime_field_arithmetic_unit.sv
// top level: front classifier, two-entry job queue, square-and-multiply back end
`timescale 1ns / 1ps
// Prime field unit over a modulus p written through cfg_we/cfg_wdata (values below 2 act
// as 2). An item is taken when start is high and busy is low; one result follows with
// strobe high for one cycle, and the receiver cannot stall it. The front reduces a, b and
// the exponent with a bit-serial reducer, and the back end runs square-and-multiply on one
// multiplier whose products go through a bit-serial reducer, so power and invert take up
// to about 2*RESIDUE_WIDTH products, a power with a negative exponent about twice as
// many; a queue of two jobs lets the front take the next item while the back end works.
module prime_field_arithmetic_unit #(
	parameter int RESIDUE_WIDTH = 26
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [RESIDUE_WIDTH-1:0] cfg_wdata,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               func,
	input  logic [RESIDUE_WIDTH-1:0] operand_a,
	input  logic [RESIDUE_WIDTH-1:0] operand_b,
	input  logic signed [31:0]       exponent,
	output logic                     strobe,
	output logic [RESIDUE_WIDTH-1:0] value,
	output logic                     div_by_zero
);
	import pfau_pkg::*;

	localparam int RW = RESIDUE_WIDTH;

	typedef struct packed {
		logic [1:0]    kind;
		logic [RW-1:0] x;
		logic [RW-1:0] y;
		logic [RW:0]   e;
		logic [RW-1:0] v;
		logic          flag;
		logic          neg;
	} job_t;

	logic [RW-1:0] mod_q, p;
	logic          push, pop, q_full;
	job_t          fj, q_mem [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	job_t          hj;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_q <= RW'(2);
		else if (cfg_we) mod_q <= cfg_wdata;
	end
	assign p = (mod_q < RW'(2)) ? RW'(2) : mod_q;

	pfau_front #(.RW(RW)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.operand_a(operand_a), .operand_b(operand_b), .exponent(exponent),
		.p(p), .q_full(q_full), .busy(busy), .push(push),
		.job_kind(fj.kind), .job_x(fj.x), .job_y(fj.y), .job_e(fj.e),
		.job_v(fj.v), .job_flag(fj.flag), .job_neg(fj.neg)
	);

	// job queue
	assign q_full = cnt_q == 2'd2;
	assign hj = q_mem[rp_q];
	always_ff @(posedge clk) if (push) q_mem[wp_q] <= fj;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	pfau_back #(.RW(RW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(cnt_q != 2'd0),
		.job_kind(hj.kind), .job_x(hj.x), .job_y(hj.y), .job_e(hj.e),
		.job_v(hj.v), .job_flag(hj.flag), .negpow(hj.neg), .p(p),
		.pop(pop), .strobe(strobe), .value(value), .div_by_zero(div_by_zero)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop)
		else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");
`endif
endmodule

>>> rtl/core/pfau_modred.sv
// sequential reducer: x mod p by restoring shift-subtract, one bit per cycle
`timescale 1ns / 1ps
module pfau_modred #(
	parameter int XW = 64,
	parameter int PW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [XW-1:0] x,
	input  logic [PW-1:0] p,
	output logic          done,
	output logic [PW-1:0] rem
);
	localparam int CW = $clog2(XW + 1);

	logic [XW-1:0] x_q;
	logic [PW:0]   r_q;
	logic [PW-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [PW+1:0] sh;
	logic [PW+1:0] df;

	// one restoring step
	assign sh = {r_q, x_q[XW-1]};
	assign df = sh - {2'b00, p_q};

	// bit loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(XW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= x;
			r_q <= '0;
			p_q <= p;
		end else if (run_q) begin
			x_q <= x_q << 1;
			r_q <= df[PW+1] ? sh[PW:0] : df[PW:0];
		end
	end

	assign rem = r_q[PW-1:0];
endmodule

>>> rtl/core/pfau_front.sv
// front part: reduces operands, classifies each word into a job
`timescale 1ns / 1ps
module pfau_front #(
	parameter int RW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    func,
	input  logic [RW-1:0] operand_a,
	input  logic [RW-1:0] operand_b,
	input  logic [31:0]   exponent,
	input  logic [RW-1:0] p,
	input  logic          q_full,
	output logic          busy,
	output logic          push,
	output logic [1:0]    job_kind,
	output logic [RW-1:0] job_x,
	output logic [RW-1:0] job_y,
	output logic [RW:0]   job_e,
	output logic [RW-1:0] job_v,
	output logic          job_flag,
	output logic          job_neg
);
	import pfau_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RA = 3'd1;
	localparam logic [2:0] ST_RB = 3'd2;
	localparam logic [2:0] ST_RE = 3'd3;
	localparam logic [2:0] ST_CL = 3'd4;
	localparam logic [2:0] ST_PUSH = 3'd5;

	logic [2:0]    state_q;
	logic [2:0]    func_q;
	logic [RW-1:0] a_q, b_q;
	logic [31:0]   e_q;
	logic          eneg_q;
	logic [RW:0]   emod_q;
	logic          go;
	logic [63:0]   rx;
	logic [RW:0]   rp;
	logic          rdone;
	logic [RW:0]   rrem;
	logic [RW:0]   ar;
	logic [RW:0]   bs;

	pfau_modred #(.XW(64), .PW(RW + 1)) u_red (
		.clk(clk), .arst_n(arst_n), .go(go), .x(rx), .p(rp),
		.done(rdone), .rem(rrem)
	);

	// reducer input selection per state
	always_comb begin
		go = 1'b0;
		rx = '0;
		rp = {1'b0, p};
		case (state_q)
			ST_IDLE: begin
				go = start;
				rx = 64'(operand_a);
			end
			ST_RA: begin
				go = rdone;
				rx = 64'(b_q);
			end
			ST_RB: begin
				go = rdone;
				rx = 64'(e_q);
				rp = {1'b0, p} - 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign ar = {1'b0, a_q} + {1'b0, b_q};
	assign bs = {1'b0, a_q} + {1'b0, p} - {1'b0, b_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_RA;
				ST_RA: if (rdone) state_q <= ST_RB;
				ST_RB: if (rdone) state_q <= ST_RE;
				ST_RE: if (rdone) state_q <= ST_CL;
				ST_CL: state_q <= ST_PUSH;
				ST_PUSH: if (!q_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign push = (state_q == ST_PUSH) && !q_full;

	// operand capture and classification
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q <= func;
			b_q <= operand_b;
			eneg_q <= exponent[31];
			e_q <= exponent[31] ? (32'd0 - exponent) : exponent;
		end
		if (state_q == ST_RA && rdone) a_q <= rrem[RW-1:0];
		if (state_q == ST_RB && rdone) b_q <= rrem[RW-1:0];
		if (state_q == ST_RE && rdone) emod_q <= rrem;
		if (state_q == ST_CL) begin
			job_kind <= JOB_DONE;
			job_x <= a_q;
			job_y <= b_q;
			job_e <= {1'b0, p} - 2'd2;
			job_v <= '0;
			job_flag <= 1'b0;
			job_neg <= 1'b0;
			case (func_q)
				FUNC_ADD: job_v <= (ar >= {1'b0, p}) ? RW'(ar - {1'b0, p}) : ar[RW-1:0];
				FUNC_SUB: job_v <= (bs >= {1'b0, p}) ? RW'(bs - {1'b0, p}) : bs[RW-1:0];
				FUNC_MUL: job_kind <= JOB_MUL;
				FUNC_DIV: begin
					if (b_q == '0) job_flag <= 1'b1;
					else job_kind <= JOB_DIV;
				end
				FUNC_INV: begin
					if (a_q == '0) job_flag <= 1'b1;
					else job_kind <= JOB_POW;
				end
				FUNC_POW: begin
					if (a_q == '0) begin
						job_flag <= eneg_q;
					end else if (eneg_q) begin
						// a^-e = (a^(p-2))^e
						job_kind <= JOB_DIV;
						job_x <= RW'(1);
						job_y <= a_q;
						job_e <= emod_q;
						job_neg <= 1'b1;
					end else begin
						job_kind <= JOB_POW;
						job_e <= emod_q;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/core/pfau_back.sv
// back part: square-and-multiply engine on one shared multiplier and reducer
`timescale 1ns / 1ps
module pfau_back #(
	parameter int RW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [1:0]    job_kind,
	input  logic [RW-1:0] job_x,
	input  logic [RW-1:0] job_y,
	input  logic [RW:0]   job_e,
	input  logic [RW-1:0] job_v,
	input  logic          job_flag,
	input  logic          negpow,
	input  logic [RW-1:0] p,
	output logic          pop,
	output logic          strobe,
	output logic [RW-1:0] value,
	output logic          div_by_zero
);
	import pfau_pkg::*;

	localparam logic [2:0] BS_IDLE = 3'd0;
	localparam logic [2:0] BS_STEP = 3'd1; // decide next product
	localparam logic [2:0] BS_MUL = 3'd2;  // product registered
	localparam logic [2:0] BS_RED = 3'd3;  // wait for reduction
	localparam logic [2:0] BS_OUT = 3'd4;

	localparam logic [1:0] OP_R = 2'd0; // r = r*base
	localparam logic [1:0] OP_B = 2'd1; // base = base^2
	localparam logic [1:0] OP_F = 2'd2; // final r = r*x
	localparam logic [1:0] OP_P = 2'd3; // not used; invert then power restarts with new e in BS_STEP

	logic [2:0]    state_q;
	logic [1:0]    op_q;
	logic [1:0]    kind_q;
	logic [RW-1:0] r_q, base_q, x_q;
	logic [RW:0]   e_q, e2_q;
	logic          second_q;
	logic [RW-1:0] ma, mb;
	logic [2*RW-1:0] prod_s1;
	logic          go;
	logic          go_q;
	logic          rdone;
	logic [RW-1:0] rrem;

	pfau_modred #(.XW(2 * RW), .PW(RW)) u_red (
		.clk(clk), .arst_n(arst_n), .go(go), .x(prod_s1), .p(p),
		.done(rdone), .rem(rrem)
	);

	assign pop = (state_q == BS_IDLE) && q_valid;
	// start the reducer once the product register holds the new product
	assign go = go_q;

	// operand selection for the shared multiplier
	always_comb begin
		ma = r_q;
		mb = base_q;
		case (op_q)
			OP_B: ma = base_q;
			OP_F: mb = x_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) prod_s1 <= ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			strobe <= 1'b0;
			go_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			go_q <= state_q == BS_MUL;
			case (state_q)
				BS_IDLE: begin
					if (q_valid) begin
						value <= job_v;
						div_by_zero <= job_flag;
						kind_q <= job_kind;
						x_q <= job_x;
						r_q <= (p == RW'(1)) ? '0 : RW'(1);
						base_q <= job_y;
						second_q <= negpow;
						e2_q <= job_e;
						if (job_kind == JOB_DONE) begin
							state_q <= BS_OUT;
						end else if (job_kind == JOB_MUL) begin
							r_q <= job_x;
							base_q <= job_y;
							e_q <= '0;
							op_q <= OP_R;
							state_q <= BS_MUL;
						end else begin
							if (job_kind == JOB_POW) base_q <= job_x;
							e_q <= (job_kind == JOB_POW || !negpow) ? job_e
								: {1'b0, p} - 2'd2;
							state_q <= BS_STEP;
						end
					end
				end
				BS_STEP: begin
					if (e_q == '0) begin
						if (kind_q == JOB_DIV && second_q) begin
							// inverse ready: raise it to the exponent
							second_q <= 1'b0;
							kind_q <= JOB_POW;
							base_q <= r_q;
							r_q <= (p == RW'(1)) ? '0 : RW'(1);
							e_q <= e2_q;
						end else if (kind_q == JOB_DIV) begin
							op_q <= OP_F;
							kind_q <= JOB_POW;
							state_q <= BS_MUL;
						end else begin
							value <= r_q;
							state_q <= BS_OUT;
						end
					end else if (e_q[0]) begin
						op_q <= OP_R;
						e_q[0] <= 1'b0;
						state_q <= BS_MUL;
					end else begin
						op_q <= OP_B;
						e_q <= e_q >> 1;
						state_q <= (e_q >> 1) == '0 ? BS_STEP : BS_MUL;
					end
				end
				BS_MUL: state_q <= BS_RED;
				BS_RED: begin
					if (rdone) begin
						if (op_q == OP_B) base_q <= rrem;
						else r_q <= rrem;
						if (kind_q == JOB_MUL) begin
							value <= rrem;
							state_q <= BS_OUT;
						end else if (op_q == OP_F) begin
							value <= rrem;
							state_q <= BS_OUT;
						end else begin
							state_q <= BS_STEP;
						end
					end
				end
				BS_OUT: begin
					strobe <= 1'b1;
					state_q <= BS_IDLE;
				end
				default: state_q <= BS_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != BS_IDLE)
		else $error("pop without leaving idle");
	a_strobe_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == BS_OUT)
		else $error("strobe outside output state");
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && div_by_zero |-> value == '0)
		else $error("flagged result not zero");
`endif
endmodule
